// ===== rtl/m3i_pkg.sv =====
// Shared types and constants for the 3x3 fixed-point matrix inverse.
// Used by every module of the block; depends on nothing.
package m3i_pkg;

    // entry width and derived widths
    localparam int EW   = 32;            // entry / result width
    localparam int CW   = 2 * EW + 2;    // signed cofactor width
    localparam int HW   = CW / 2;        // low half of a cofactor for the det split
    localparam int DW   = 3 * EW + 2;    // signed determinant width
    localparam int MW   = DW - 1;        // determinant magnitude width
    localparam int CMW  = CW - 1;        // cofactor magnitude width
    localparam int NSTG = EW;            // quotient bits, one divider stage each
    localparam int NE   = 9;             // entries per matrix

    // queue between front and back
    localparam int FQ_DEPTH = 4;
    localparam int FQ_AW    = $clog2(FQ_DEPTH);
    localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

    // cofactor n = a[P]*a[Q] - a[R]*a[S], index r*3+c
    localparam int CF_P [NE] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int CF_Q [NE] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int CF_R [NE] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int CF_S [NE] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
    // determinant expands along column 0
    localparam int DT_A [3] = '{0, 3, 6};

    typedef struct packed {
        logic signed [EW-1:0] a_00;
        logic signed [EW-1:0] a_01;
        logic signed [EW-1:0] a_02;
        logic signed [EW-1:0] a_10;
        logic signed [EW-1:0] a_11;
        logic signed [EW-1:0] a_12;
        logic signed [EW-1:0] a_20;
        logic signed [EW-1:0] a_21;
        logic signed [EW-1:0] a_22;
    } t_in;

    typedef struct packed {
        logic signed [EW-1:0] inv_00;
        logic signed [EW-1:0] inv_01;
        logic signed [EW-1:0] inv_02;
        logic signed [EW-1:0] inv_10;
        logic signed [EW-1:0] inv_11;
        logic signed [EW-1:0] inv_12;
        logic signed [EW-1:0] inv_20;
        logic signed [EW-1:0] inv_21;
        logic signed [EW-1:0] inv_22;
        logic                 singular;
    } t_out;

    // exact cofactors and determinant handed from front to back
    typedef struct packed {
        logic [NE-1:0][CW-1:0] cof;
        logic [DW-1:0]         det;
    } t_job;

endpackage

// ===== rtl/m3i_front.sv =====
// Front end: exact cofactors and determinant of one matrix per cycle.
// Depends on m3i_pkg.
module m3i_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  m3i_pkg::t_in    i_item,
    output logic            o_valid,
    output m3i_pkg::t_job   o_job
);

    logic signed [m3i_pkg::EW-1:0]   a      [m3i_pkg::NE];
    logic                            r_v1, r_v2, r_v3, r_v4;
    logic signed [m3i_pkg::EW-1:0]   r_a    [m3i_pkg::NE];
    logic signed [2*m3i_pkg::EW-1:0] r_pa   [m3i_pkg::NE];
    logic signed [2*m3i_pkg::EW-1:0] r_pb   [m3i_pkg::NE];
    logic signed [m3i_pkg::EW-1:0]   r_ad2  [3];
    logic signed [m3i_pkg::EW-1:0]   r_ad3  [3];
    logic signed [m3i_pkg::CW-1:0]   r_cof3 [m3i_pkg::NE];
    logic signed [m3i_pkg::CW-1:0]   r_cof4 [m3i_pkg::NE];
    logic signed [m3i_pkg::EW+m3i_pkg::HW+1:0] r_lo [3];
    logic signed [m3i_pkg::CW-1:0]   r_hi   [3];
    logic signed [m3i_pkg::DW-1:0]   det;

    // unpack entries in row-major order
    assign a[0] = i_item.a_00;
    assign a[1] = i_item.a_01;
    assign a[2] = i_item.a_02;
    assign a[3] = i_item.a_10;
    assign a[4] = i_item.a_11;
    assign a[5] = i_item.a_12;
    assign a[6] = i_item.a_20;
    assign a[7] = i_item.a_21;
    assign a[8] = i_item.a_22;

    // advance valid through the four stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    for (genvar l = 0; l < m3i_pkg::NE; l++) begin : g_cof
        // capture entry, then the two products, then their difference
        always_ff @(posedge i_clk) begin
            r_a[l]    <= a[l];
            r_pa[l]   <= r_a[m3i_pkg::CF_P[l]] * r_a[m3i_pkg::CF_Q[l]];
            r_pb[l]   <= r_a[m3i_pkg::CF_R[l]] * r_a[m3i_pkg::CF_S[l]];
            r_cof3[l] <= m3i_pkg::CW'(r_pa[l]) - m3i_pkg::CW'(r_pb[l]);
            r_cof4[l] <= r_cof3[l];
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_det
        // split the cofactor so each product stays near 32 by 32
        always_ff @(posedge i_clk) begin
            r_ad2[k] <= r_a[m3i_pkg::DT_A[k]];
            r_ad3[k] <= r_ad2[k];
            r_lo[k]  <= r_ad3[k] * $signed({1'b0, r_cof3[k][m3i_pkg::HW-1:0]});
            r_hi[k]  <= r_ad3[k] * $signed(r_cof3[k][m3i_pkg::CW-1:m3i_pkg::HW]);
        end
    end

    // recombine partial products into the determinant
    always_comb begin
        det = '0;
        for (int k = 0; k < 3; k++) begin
            det = det + (m3i_pkg::DW'(r_hi[k]) <<< m3i_pkg::HW) + m3i_pkg::DW'(r_lo[k]);
        end
    end

    always_comb begin
        for (int l = 0; l < m3i_pkg::NE; l++) begin
            o_job.cof[l] = r_cof4[l];
        end
        o_job.det = det;
    end
    assign o_valid = r_v4;

endmodule

// ===== rtl/m3i_fifo.sv =====
// Short queue between front and back ends.
// Depends on m3i_pkg.
module m3i_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  m3i_pkg::t_job   i_data,
    input  logic            i_pop,
    output logic            o_empty,
    output logic            o_full,
    output m3i_pkg::t_job   o_data
);

    m3i_pkg::t_job              r_mem [m3i_pkg::FQ_DEPTH];
    logic [m3i_pkg::FQ_AW-1:0]  r_wp, r_rp;
    logic [m3i_pkg::FQ_CW-1:0]  r_cnt;
    logic                       do_push, do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == m3i_pkg::FQ_CW'(m3i_pkg::FQ_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    // store entry
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("queue push while full");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= m3i_pkg::FQ_CW'(m3i_pkg::FQ_DEPTH))
        else $error("queue count out of range");
    a_cnt_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count did not advance");

endmodule

// ===== rtl/m3i_back.sv =====
// Back end: sign split, 32-stage restoring divider per entry, saturation.
// Depends on m3i_pkg.
module m3i_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  m3i_pkg::t_job   i_job,
    output logic            o_valid,
    output m3i_pkg::t_out   o_result
);

    localparam int NS = m3i_pkg::NSTG;
    localparam int MW = m3i_pkg::MW;
    localparam int EW = m3i_pkg::EW;
    localparam int NE = m3i_pkg::NE;

    logic signed [m3i_pkg::DW-1:0]  det;
    logic                           dneg;
    logic [MW-1:0]                  dmag;
    logic [MW-1:0]                  nmag [NE];
    logic                           nneg [NE];
    logic                           novf [NE];

    logic              r_v   [NS+1];
    logic              r_sg  [NS+1];
    logic [MW-1:0]     r_d   [NS+1];
    logic [MW-1:0]     r_rem [NS+1][NE];
    logic [EW-1:0]     r_q   [NS+1][NE];
    logic              r_ng  [NS+1][NE];
    logic              r_ov  [NS+1][NE];
    logic              r_ov_v;
    m3i_pkg::t_out     r_out;
    logic [EW-1:0]     res   [NE];

    // classify: magnitudes, signs, singular and quotient overflow
    always_comb begin
        logic signed [m3i_pkg::CW-1:0] c;
        logic [m3i_pkg::CMW-1:0]       cm;
        det  = $signed(i_job.det);
        dneg = det[m3i_pkg::DW-1];
        dmag = dneg ? MW'(-det) : MW'(det);
        for (int l = 0; l < NE; l++) begin
            c       = $signed(i_job.cof[l]);
            cm      = c[m3i_pkg::CW-1] ? m3i_pkg::CMW'(-c) : m3i_pkg::CMW'(c);
            nmag[l] = MW'(cm);
            nneg[l] = c[m3i_pkg::CW-1] ^ dneg;
            novf[l] = (MW'(cm) >= dmag);
        end
    end

    // load divider stage zero
    always_ff @(posedge i_clk) begin
        r_sg[0] <= (det == '0);
        r_d[0]  <= dmag;
        for (int l = 0; l < NE; l++) begin
            r_rem[0][l] <= nmag[l];
            r_q[0][l]   <= '0;
            r_ng[0][l]  <= nneg[l];
            r_ov[0][l]  <= novf[l];
        end
    end

    // advance valid along the divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= NS; s++) begin
                r_v[s] <= 1'b0;
            end
            r_ov_v <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
            for (int s = 0; s < NS; s++) begin
                r_v[s+1] <= r_v[s];
            end
            r_ov_v <= r_v[NS];
        end
    end

    // one quotient bit per stage: shift, compare, subtract
    for (genvar s = 0; s < NS; s++) begin : g_stg
        always_ff @(posedge i_clk) begin
            logic [MW:0] sh;
            logic [MW:0] df;
            r_sg[s+1] <= r_sg[s];
            r_d[s+1]  <= r_d[s];
            for (int l = 0; l < NE; l++) begin
                sh = {r_rem[s][l], 1'b0};
                df = sh - {1'b0, r_d[s]};
                if (sh >= {1'b0, r_d[s]}) begin
                    r_rem[s+1][l] <= df[MW-1:0];
                    r_q[s+1][l]   <= {r_q[s][l][EW-2:0], 1'b1};
                end else begin
                    r_rem[s+1][l] <= sh[MW-1:0];
                    r_q[s+1][l]   <= {r_q[s][l][EW-2:0], 1'b0};
                end
                r_ng[s+1][l] <= r_ng[s][l];
                r_ov[s+1][l] <= r_ov[s][l];
            end
        end
    end

    // saturate, apply sign, zero on singular
    always_comb begin
        logic [EW-1:0] q;
        for (int l = 0; l < NE; l++) begin
            q = r_q[NS][l];
            if (r_sg[NS]) begin
                res[l] = '0;
            end else if (r_ng[NS][l]) begin
                if (r_ov[NS][l] || (q[EW-1] && (q[EW-2:0] != '0))) begin
                    res[l] = {1'b1, {(EW-1){1'b0}}};
                end else begin
                    res[l] = -q;
                end
            end else begin
                if (r_ov[NS][l] || q[EW-1]) begin
                    res[l] = {1'b0, {(EW-1){1'b1}}};
                end else begin
                    res[l] = q;
                end
            end
        end
    end

    // hold result for one strobe cycle
    always_ff @(posedge i_clk) begin
        r_out.inv_00   <= res[0];
        r_out.inv_01   <= res[1];
        r_out.inv_02   <= res[2];
        r_out.inv_10   <= res[3];
        r_out.inv_11   <= res[4];
        r_out.inv_12   <= res[5];
        r_out.inv_20   <= res[6];
        r_out.inv_21   <= res[7];
        r_out.inv_22   <= res[8];
        r_out.singular <= r_sg[NS];
    end

    assign o_valid  = r_ov_v;
    assign o_result = r_out;

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov_v && r_out.singular) |-> (r_out.inv_00 == '0 && r_out.inv_11 == '0
            && r_out.inv_22 == '0 && r_out.inv_01 == '0))
        else $error("singular result with nonzero entries");
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[0] && !r_sg[0]) |-> (r_d[0] != '0))
        else $error("nonsingular transaction with zero divisor");
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[1] && !r_sg[1] && !r_ov[1][0]) |-> (r_rem[1][0] < r_d[1]))
        else $error("divider remainder not below divisor");

endmodule

// ===== rtl/matrix3_inverse_top.sv =====
// Path: the front stages, the queue, divider stage zero, the divider stages, then the output register.
// Throughput: one matrix per cycle; the 32-stage divider pipeline sets the depth.
// busy rises only if the front-to-back queue fills, which a non-stalling back end avoids.
// Reset (synchronous, active low) drops all transactions in flight.
// Depends on m3i_pkg, m3i_front, m3i_fifo, m3i_back.
module matrix3_inverse_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  m3i_pkg::t_in    i_item,
    output logic            busy,
    output logic            o_valid,
    output m3i_pkg::t_out   o_result
);

    logic           f_valid;
    m3i_pkg::t_job  f_job;
    logic           q_empty, q_full;
    m3i_pkg::t_job  q_job;
    logic           pop;

    assign busy = q_full;
    assign pop  = !q_empty;

    m3i_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !q_full),
        .i_item  (i_item),
        .o_valid (f_valid),
        .o_job   (f_job)
    );

    m3i_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (f_job),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_data  (q_job)
    );

    m3i_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (pop),
        .i_job    (q_job),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

// ===== test/matrix3_inverse_top_test.sv =====
// Testbench for matrix3_inverse_top: drives 3x3 Q16.16 matrices and checks each inverse.
// Expected results come from an exact wide-integer adjugate model in this file.
// Depends on m3i_pkg and the matrix3_inverse_top RTL.
module matrix3_inverse_top_test;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 60;

    // sender idle percentages for each phase
    localparam int IDLE_NONE = 0;
    localparam int IDLE_HIGH = 63;
    localparam int IDLE_LOW  = 21;

    typedef logic signed [255:0] t_wide;

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    m3i_pkg::t_in   i_item;
    logic           busy;
    logic           o_valid;
    m3i_pkg::t_out  o_result;

    m3i_pkg::t_out  expected_inverses[$];
    int    mismatch_count;
    int    quiet_cycles;
    int    sender_idle_pct;

    matrix3_inverse_top uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // clock generation
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // truncated quotient of one cofactor by the determinant, saturated to 32 bits
    function automatic logic signed [m3i_pkg::EW-1:0] inverse_entry(t_wide cof, t_wide det);
        t_wide num;
        t_wide quo;
        t_wide max_pos;
        t_wide min_neg;
        max_pos = 256'sd2147483647;
        min_neg = -256'sd2147483648;
        num = cof <<< 32;
        quo = num / det;
        if (quo > max_pos) return max_pos[m3i_pkg::EW-1:0];
        if (quo < min_neg) return min_neg[m3i_pkg::EW-1:0];
        return quo[m3i_pkg::EW-1:0];
    endfunction

    // exact adjugate over determinant
    function automatic m3i_pkg::t_out invert_matrix(m3i_pkg::t_in m);
        t_wide a [m3i_pkg::NE];
        t_wide cof [m3i_pkg::NE];
        t_wide det;
        logic signed [m3i_pkg::EW-1:0] res [m3i_pkg::NE];
        m3i_pkg::t_out r;
        a[0] = m.a_00; a[1] = m.a_01; a[2] = m.a_02;
        a[3] = m.a_10; a[4] = m.a_11; a[5] = m.a_12;
        a[6] = m.a_20; a[7] = m.a_21; a[8] = m.a_22;
        cof[0] = a[4] * a[8] - a[5] * a[7];
        cof[1] = a[2] * a[7] - a[1] * a[8];
        cof[2] = a[1] * a[5] - a[2] * a[4];
        cof[3] = a[5] * a[6] - a[3] * a[8];
        cof[4] = a[0] * a[8] - a[2] * a[6];
        cof[5] = a[2] * a[3] - a[0] * a[5];
        cof[6] = a[3] * a[7] - a[4] * a[6];
        cof[7] = a[1] * a[6] - a[0] * a[7];
        cof[8] = a[0] * a[4] - a[1] * a[3];
        det = a[0] * cof[0] + a[3] * cof[1] + a[6] * cof[2];
        r = '0;
        if (det == 0) begin
            r.singular = 1'b1;
            return r;
        end
        for (int i = 0; i < m3i_pkg::NE; i++) res[i] = inverse_entry(cof[i], det);
        r.inv_00 = res[0]; r.inv_01 = res[1]; r.inv_02 = res[2];
        r.inv_10 = res[3]; r.inv_11 = res[4]; r.inv_12 = res[5];
        r.inv_20 = res[6]; r.inv_21 = res[7]; r.inv_22 = res[8];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [m3i_pkg::EW-1:0] got,
                                   logic [m3i_pkg::EW-1:0] want);
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // check each result against the oldest expected inverse
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_inverses.size() == 0) begin
                report_mismatch("unexpected result", o_result.inv_00, '0);
            end else begin
                m3i_pkg::t_out w;
                w = expected_inverses.pop_front();
                if (o_result.inv_00 !== w.inv_00) report_mismatch("inv_00", o_result.inv_00, w.inv_00);
                if (o_result.inv_01 !== w.inv_01) report_mismatch("inv_01", o_result.inv_01, w.inv_01);
                if (o_result.inv_02 !== w.inv_02) report_mismatch("inv_02", o_result.inv_02, w.inv_02);
                if (o_result.inv_10 !== w.inv_10) report_mismatch("inv_10", o_result.inv_10, w.inv_10);
                if (o_result.inv_11 !== w.inv_11) report_mismatch("inv_11", o_result.inv_11, w.inv_11);
                if (o_result.inv_12 !== w.inv_12) report_mismatch("inv_12", o_result.inv_12, w.inv_12);
                if (o_result.inv_20 !== w.inv_20) report_mismatch("inv_20", o_result.inv_20, w.inv_20);
                if (o_result.inv_21 !== w.inv_21) report_mismatch("inv_21", o_result.inv_21, w.inv_21);
                if (o_result.inv_22 !== w.inv_22) report_mismatch("inv_22", o_result.inv_22, w.inv_22);
                if (o_result.singular !== w.singular)
                    report_mismatch("singular", m3i_pkg::EW'(o_result.singular),
                                    m3i_pkg::EW'(w.singular));
            end
        end
    end

    // watchdog: count cycles with no transaction in either direction
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // send one matrix; start stays high across back-to-back transactions
    task automatic send_matrix(m3i_pkg::t_in m);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= m;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_inverses.push_back(invert_matrix(m));
        @(negedge i_clk);
    endtask

    // drop start and hold it low for one cycle
    task automatic end_burst();
        start <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [m3i_pkg::EW-1:0] random_entry();
        case ($urandom_range(5))
            0: return $urandom;
            1: return {{16{1'($urandom_range(1))}}, 16'($urandom)};   // near unit magnitude
            2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            3: return 32'($signed($urandom_range(8)) - 4) <<< 16;  // small integers
            4: return 32'($signed($urandom_range(6)) - 3);          // tiny raw values
            default: return {{8{1'($urandom_range(1))}}, 24'($urandom)};
        endcase
    endfunction

    function automatic m3i_pkg::t_in random_matrix();
        m3i_pkg::t_in m;
        m = {random_entry(), random_entry(), random_entry(), random_entry(), random_entry(),
             random_entry(), random_entry(), random_entry(), random_entry()};
        // make some rows dependent so the singular path is reached
        if ($urandom_range(9) == 0) begin
            m.a_20 = m.a_00; m.a_21 = m.a_01; m.a_22 = m.a_02;
        end
        return m;
    endfunction

    // extremes, identity, singular, saturation and sign cases
    task automatic test_directed();
        localparam logic [m3i_pkg::EW-1:0] ONE  = 32'h0001_0000;
        localparam logic [m3i_pkg::EW-1:0] MAXV = 32'h7FFF_FFFF;
        localparam logic [m3i_pkg::EW-1:0] MINV = 32'h8000_0000;
        sender_idle_pct = IDLE_NONE;
        send_matrix({ONE, 32'h0, 32'h0, 32'h0, ONE, 32'h0, 32'h0, 32'h0, ONE});
        send_matrix('0);
        send_matrix({9{MAXV}});
        send_matrix({9{MINV}});
        send_matrix({9{32'hFFFF_FFFF}});
        send_matrix({MAXV, 32'h0, 32'h0, 32'h0, MAXV, 32'h0, 32'h0, 32'h0, MAXV});
        send_matrix({MINV, 32'h0, 32'h0, 32'h0, MINV, 32'h0, 32'h0, 32'h0, MINV});
        send_matrix({32'h1, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 32'h1});
        send_matrix({32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 32'h1});
        send_matrix({32'h0, ONE, 32'h0, ONE, 32'h0, 32'h0, 32'h0, 32'h0, ONE});
        send_matrix({32'h0002_0000, ONE, 32'h0, ONE, 32'h0003_0000, ONE, 32'h0, ONE,
                     32'h0004_0000});
        send_matrix({ONE, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'h0005_0000,
                     32'h0006_0000, 32'h0007_0000, 32'h0008_0000, 32'h0009_0000});
        send_matrix({MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV});
        send_matrix({MINV, MAXV, 32'h0, MAXV, MINV, 32'h0, 32'h0, 32'h0, ONE});
        send_matrix({32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 32'hAAAA_AAAA, 32'h5555_5555,
                     32'h8765_4321, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h3333_3333});
        end_burst();
    endtask

    task automatic test_random_phase(int idle_pct, int count);
        sender_idle_pct = idle_pct;
        repeat (count) send_matrix(random_matrix());
        end_burst();
    endtask

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        mismatch_count  = 0;
        quiet_cycles    = 0;
        sender_idle_pct = IDLE_NONE;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random_phase(IDLE_NONE, 400);
        test_random_phase(IDLE_HIGH, 400);
        test_random_phase(IDLE_NONE, 350);
        test_random_phase(IDLE_LOW, 400);

        // drain outstanding results, then allow the pipeline latency
        while (expected_inverses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/m3i_pkg.sv
rtl/m3i_front.sv
rtl/m3i_fifo.sv
rtl/m3i_back.sv
rtl/matrix3_inverse_top.sv
test/matrix3_inverse_top_test.sv
